// File: design/spcr_pkg.sv
// types, constants and the byte-wide crc update shared by the space packet receiver
// no dependencies

package spcr_pkg;

    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam int          PRI_BYTES    = 6;
    localparam int          SEC_BYTES    = 5;
    localparam logic [16:0] LEN_OVERHEAD = 17'd7;

    typedef struct packed {
        logic        status;
        logic [2:0]  version;
        logic        packet_kind;
        logic        has_secondary;
        logic [10:0] apid;
        logic [1:0]  seq_flags;
        logic [13:0] seq_count;
        logic [15:0] data_length;
        logic [3:0]  ack_request;
        logic [7:0]  service_id;
        logic [7:0]  subtype_id;
        logic [15:0] origin_id;
    } result_t;

    // crc-16-ccitt, msb first, one byte unrolled
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic [7:0]  d;
        logic        top;
        c = crc;
        d = b;
        for (int k = 0; k < 8; k++) begin
            top = c[15] ^ d[7];
            c   = {c[14:0], 1'b0};
            if (top) begin
                c = c ^ CRC_POLY;
            end
            d = {d[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: design/space_packet_crc_receiver.sv
// space packet receiver: one byte a cycle while m_ready does not stall the output, one result per complete packet
// result: the final byte passes the input register, then the result register
// throughput: one byte per cycle unless m_ready stalls the output; the byte crc update is combinational
// reset: clears input and result valids and the receiving flag; beats before a first beat are dropped
// depends on spcr_pkg and spcr_core

module space_packet_crc_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [2:0]  m_version,
    output logic        m_packet_kind,
    output logic        m_has_secondary,
    output logic [10:0] m_apid,
    output logic [1:0]  m_seq_flags,
    output logic [13:0] m_seq_count,
    output logic [15:0] m_data_length,
    output logic [3:0]  m_ack_request,
    output logic [7:0]  m_service_id,
    output logic [7:0]  m_subtype_id,
    output logic [15:0] m_origin_id
);

    logic              in_valid_reg;
    logic [7:0]        in_data_reg;
    logic              in_first_reg;
    logic              out_valid_reg;
    spcr_pkg::result_t result_reg;

    logic              advance;
    logic              step_en;
    logic              emit;
    spcr_pkg::result_t result;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign step_en = in_valid_reg && advance;

    spcr_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .data_byte  (in_data_reg),
        .first_byte (in_first_reg),
        .emit       (emit),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= step_en && emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg  <= s_data_byte;
            in_first_reg <= s_first_byte;
        end
        if (step_en && emit) begin
            result_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = result_reg.status;
    assign m_version       = result_reg.version;
    assign m_packet_kind   = result_reg.packet_kind;
    assign m_has_secondary = result_reg.has_secondary;
    assign m_apid          = result_reg.apid;
    assign m_seq_flags     = result_reg.seq_flags;
    assign m_seq_count     = result_reg.seq_count;
    assign m_data_length   = result_reg.data_length;
    assign m_ack_request   = result_reg.ack_request;
    assign m_service_id    = result_reg.service_id;
    assign m_subtype_id    = result_reg.subtype_id;
    assign m_origin_id     = result_reg.origin_id;

endmodule

// File: design/spcr_core.sv
// per-byte packet state: header capture, length tracking and crc check
// depends on spcr_pkg

module spcr_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  logic [7:0]            data_byte,
    input  logic                  first_byte,
    output logic                  emit,
    output spcr_pkg::result_t     result
);

    logic        receiving_reg, receiving_next;
    logic [16:0] byte_index_reg, byte_index_next;
    logic [16:0] total_bytes_reg, total_bytes_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_high_reg, crc_high_next;
    logic [47:0] primary_reg, primary_next;
    logic [39:0] secondary_reg, secondary_next;

    logic        active;
    logic [16:0] idx;
    logic [15:0] crc_base;
    logic [7:0]  high_base;
    logic [17:0] idx_p2, idx_p1, total_ext;

    always_comb begin
        active    = first_byte || receiving_reg;
        idx       = first_byte ? 17'd0 : byte_index_reg;
        crc_base  = first_byte ? spcr_pkg::CRC_INIT : crc_reg;
        high_base = first_byte ? 8'd0 : crc_high_reg;

        primary_next   = first_byte ? 48'd0 : primary_reg;
        secondary_next = first_byte ? 40'd0 : secondary_reg;
        for (int k = 0; k < spcr_pkg::PRI_BYTES; k++) begin
            if (idx == 17'(k)) begin
                primary_next[8*(spcr_pkg::PRI_BYTES-1-k) +: 8] = data_byte;
            end
        end
        for (int k = 0; k < spcr_pkg::SEC_BYTES; k++) begin
            if (idx == 17'(spcr_pkg::PRI_BYTES + k)) begin
                secondary_next[8*(spcr_pkg::SEC_BYTES-1-k) +: 8] = data_byte;
            end
        end

        total_bytes_next = first_byte ? 17'd0 : total_bytes_reg;
        if (idx == 17'(spcr_pkg::PRI_BYTES - 1)) begin
            total_bytes_next = {1'b0, primary_next[15:0]} + spcr_pkg::LEN_OVERHEAD;
        end

        idx_p2    = {1'b0, idx} + 18'd2;
        idx_p1    = {1'b0, idx} + 18'd1;
        total_ext = {1'b0, total_bytes_next};

        crc_next        = crc_base;
        crc_high_next   = high_base;
        emit            = 1'b0;
        receiving_next  = active;
        byte_index_next = idx + 17'd1;
        if (idx < 17'(spcr_pkg::PRI_BYTES - 1) || idx_p2 < total_ext) begin
            crc_next = spcr_pkg::crc_feed(crc_base, data_byte);
        end else if (idx_p2 == total_ext) begin
            crc_high_next = data_byte;
        end else if (idx_p1 == total_ext) begin
            emit            = active;
            receiving_next  = 1'b0;
            byte_index_next = 17'd0;
        end

        result.status        = ({high_base, data_byte} != crc_base);
        result.version       = primary_next[47:45];
        result.packet_kind   = primary_next[44];
        result.has_secondary = primary_next[43];
        result.apid          = primary_next[42:32];
        result.seq_flags     = primary_next[31:30];
        result.seq_count     = primary_next[29:16];
        result.data_length   = primary_next[15:0];
        if (primary_next[43]) begin
            result.ack_request = secondary_next[35:32];
            result.service_id  = secondary_next[31:24];
            result.subtype_id  = secondary_next[23:16];
            result.origin_id   = secondary_next[15:0];
        end else begin
            result.ack_request = 4'd0;
            result.service_id  = 8'd0;
            result.subtype_id  = 8'd0;
            result.origin_id   = 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            receiving_reg <= 1'b0;
        end else if (step_en) begin
            receiving_reg <= receiving_next;
        end
    end

    // payload state, always reloaded by a first beat before use
    always_ff @(posedge aclk) begin
        if (step_en && active) begin
            byte_index_reg  <= byte_index_next;
            total_bytes_reg <= total_bytes_next;
            crc_reg         <= crc_next;
            crc_high_reg    <= crc_high_next;
            primary_reg     <= primary_next;
            secondary_reg   <= secondary_next;
        end
    end

endmodule
